// ===== rtl/core/aes128_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 shared definitions
// S-box, GF(2^8) doubling, round helpers and the per-stage control struct.
// ----------------------------------------------------------------------------
package aes128_pkg;

  localparam int NumRounds = 10;
  localparam logic [7:0] GfReduce = 8'h1b;

  // Configuration register byte addresses (8-byte spacing, 64-bit data)
  localparam logic [3:0] AddrKeyHigh = 4'h0;
  localparam logic [3:0] AddrKeyLow  = 4'h8;

  typedef logic [127:0] block_t;

  // What travels alongside the data from one round cell to the next
  typedef struct packed {
    logic       vld;
    logic [7:0] rcon;
  } stage_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GfReduce : 8'h00);
  endfunction

  // Byte n of a block; byte 0 sits in the top bits
  function automatic logic [7:0] get_byte(input block_t b, input int n);
    return b[127-8*n -: 8];
  endfunction

endpackage

// ===== rtl/core/aes128_block_encrypt_top.sv =====
// AES-128 encryption pipeline: input register plus ten round cells.
// The input register loads at the accepting edge, then the block passes
// through the ten round cells in order to result valid.
// Throughput: one block per cycle; the whole chain holds while out_stall is
// high and every stage is full, and only then is in_stall raised.
// Reset (synchronous, rst_n low) clears all valid flags and both key registers.
// ----------------------------------------------------------------------------
// AES-128 block encrypt top
// APB key registers, initial AddRoundKey stage and a chain of round cells.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_top
  import aes128_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_plain_high,
  input  logic [63:0] in_plain_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_cipher_high,
  output logic [63:0] out_cipher_low
);

  logic [63:0] key_high_r, key_low_r;
  stage_ctl_t  ctl   [NumRounds+1];
  block_t      st    [NumRounds+1];
  block_t      ky    [NumRounds+1];
  logic        vld_r;
  block_t      st_r, ky_r;
  logic [NumRounds:0] adv;

  // Key registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        AddrKeyHigh: key_high_r <= pwdata;
        AddrKeyLow:  key_low_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      AddrKeyHigh: prdata = key_high_r;
      AddrKeyLow:  prdata = key_low_r;
      default:     prdata = '0;
    endcase
  end

  // Stall chain: a stage moves when its successor moves or it is empty
  always_comb begin
    adv[NumRounds] = !ctl[NumRounds].vld || !out_stall;
    for (int i = NumRounds - 1; i >= 0; i--)
      adv[i] = !ctl[i].vld || adv[i+1];
  end

  assign in_stall = !adv[0];

  // Initial AddRoundKey stage
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (adv[0]) vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      st_r <= {in_plain_high, in_plain_low} ^ {key_high_r, key_low_r};
      ky_r <= {key_high_r, key_low_r};
    end
  end

  assign ctl[0] = '{vld: vld_r, rcon: 8'h01};
  assign st[0]  = st_r;
  assign ky[0]  = ky_r;

  // Round cells
  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    aes128_round_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv[g+1]),
      .last    (g == NumRounds - 1),
      .ctl_i   (ctl[g]),
      .state_i (st[g]),
      .key_i   (ky[g]),
      .ctl_o   (ctl[g+1]),
      .state_o (st[g+1]),
      .key_o   (ky[g+1])
    );
  end

  assign out_valid       = ctl[NumRounds].vld;
  assign out_cipher_high = st[NumRounds][127:64];
  assign out_cipher_low  = st[NumRounds][63:0];

`ifndef ASSERT_OFF
  // A stalled result must stay valid and hold its upper cipher half
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cipher_high))
    else $error("result changed under stall");
  // Input is never held off while the output side is free
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled with free output");
  // Accepted request shows up in the first stage
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r)
    else $error("request lost at head");
`endif

endmodule

// ===== rtl/core/aes128_round_cell.sv =====
// ----------------------------------------------------------------------------
// AES-128 round cell
// One registered round: key schedule step plus SubBytes, ShiftRows,
// optional MixColumns and AddRoundKey.
// ----------------------------------------------------------------------------
module aes128_round_cell
  import aes128_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       last,
  input  stage_ctl_t ctl_i,
  input  block_t     state_i,
  input  block_t     key_i,
  output stage_ctl_t ctl_o,
  output block_t     state_o,
  output block_t     key_o
);

  stage_ctl_t ctl_r;
  block_t     state_r, key_r;
  block_t     key_nxt, state_nxt;
  logic [7:0] rk  [16];
  logic [7:0] ss  [16];
  logic [7:0] mc  [16];
  logic [7:0] t   [4];

  // Key schedule step
  always_comb begin
    for (int i = 0; i < 16; i++) rk[i] = get_byte(key_i, i);
    t[0] = sbox(rk[13]) ^ ctl_i.rcon;
    t[1] = sbox(rk[14]);
    t[2] = sbox(rk[15]);
    t[3] = sbox(rk[12]);
    for (int i = 0; i < 4; i++) rk[i] = rk[i] ^ t[i];
    for (int i = 4; i < 16; i++) rk[i] = rk[i] ^ rk[i-4];
    for (int i = 0; i < 16; i++) key_nxt[127-8*i -: 8] = rk[i];
  end

  // SubBytes, ShiftRows, MixColumns (skipped when last), AddRoundKey
  always_comb begin
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        ss[4*c+r] = sbox(get_byte(state_i, 4*((c+r)%4)+r));
    for (int c = 0; c < 4; c++) begin
      a0 = ss[4*c]; a1 = ss[4*c+1]; a2 = ss[4*c+2]; a3 = ss[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[4*c]   = last ? a0 : a0 ^ al ^ gf_double(a0 ^ a1);
      mc[4*c+1] = last ? a1 : a1 ^ al ^ gf_double(a1 ^ a2);
      mc[4*c+2] = last ? a2 : a2 ^ al ^ gf_double(a2 ^ a3);
      mc[4*c+3] = last ? a3 : a3 ^ al ^ gf_double(a3 ^ a0);
    end
    for (int i = 0; i < 16; i++) state_nxt[127-8*i -: 8] = mc[i] ^ rk[i];
  end

  // Control: valid and the next round constant
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r.vld  <= ctl_i.vld;
      ctl_r.rcon <= gf_double(ctl_i.rcon);
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
    end
  end

  assign ctl_o   = ctl_r;
  assign state_o = state_r;
  assign key_o   = key_r;

endmodule

// ===== tb/aes128_cipher_checker.sv =====
// ----------------------------------------------------------------------------
// AES-128 ciphertext checker
// Watches key writes and the request and result channels, works out the ciphertext of
// every accepted plaintext and compares it with what the block returns.
// ----------------------------------------------------------------------------
module aes128_cipher_checker
  import aes128_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] in_plain_high,
  input  logic [63:0] in_plain_low,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_cipher_high,
  input  logic [63:0] out_cipher_low,
  output int          mismatches,
  output int          pending,
  output int          accepted
);

  logic [63:0] key_hi_q, key_lo_q;
  block_t      cipher_q[$];
  logic [7:0]  sub_lut[256];
  int          results_seen;

  // Substitution table built from its algebraic definition (inverse + affine)
  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  initial begin
    logic [7:0] inv, x;
    for (int v = 0; v < 256; v++) begin
      inv = 8'h00;
      for (int c = 1; c < 256; c++)
        if (v != 0 && gmul(v[7:0], c[7:0]) == 8'h01) inv = c[7:0];
      x = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_lut[v] = x;
    end
  end

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Full ten-round encryption; byte n = 4*column + row
  function automatic block_t encrypt(input block_t pt, input block_t key);
    logic [7:0] st[16], rk[16], tmp[16], t[4];
    logic [7:0] rc, a0, a1, a2, a3, al;
    for (int i = 0; i < 16; i++) begin
      st[i] = pt[127-8*i -: 8];
      rk[i] = key[127-8*i -: 8];
      st[i] ^= rk[i];
    end
    rc = 8'h01;
    for (int r = 1; r <= 10; r++) begin
      t[0] = sub_lut[rk[13]] ^ rc;
      t[1] = sub_lut[rk[14]];
      t[2] = sub_lut[rk[15]];
      t[3] = sub_lut[rk[12]];
      for (int i = 0; i < 4; i++) rk[i] ^= t[i];
      for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
      rc = xtime(rc);
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++)
          tmp[4*c+w] = sub_lut[st[4*((c+w)%4)+w]];
      st = tmp;
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
          st[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
          st[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
          st[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    end
    for (int i = 0; i < 16; i++) encrypt[127-8*i -: 8] = st[i];
  endfunction

  task automatic report(input string what, input logic [63:0] got,
                        input logic [63:0] want);
    $display("mismatch %s on result %0d: got %h want %h", what, results_seen, got, want);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    accepted = 0;
    results_seen = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    block_t want;
    if (!rst_n) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else begin
      // Key writes
      if (psel && penable && pwrite && pready) begin
        if (paddr == AddrKeyHigh) key_hi_q <= pwdata;
        else if (paddr == AddrKeyLow) key_lo_q <= pwdata;
      end
      // Incoming request
      if (in_valid && !in_stall) begin
        cipher_q.push_back(encrypt({in_plain_high, in_plain_low}, {key_hi_q, key_lo_q}));
        accepted++;
      end
      // Outgoing result
      if (out_valid && !out_stall) begin
        if (cipher_q.size() == 0) begin
          $display("unexpected result %h %h", out_cipher_high, out_cipher_low);
          mismatches++;
        end else begin
          want = cipher_q.pop_front();
          if (out_cipher_high !== want[127:64])
            report("cipher_high", out_cipher_high, want[127:64]);
          if (out_cipher_low !== want[63:0])
            report("cipher_low", out_cipher_low, want[63:0]);
        end
        results_seen++;
      end
      pending = cipher_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// AES-128 encrypt pipeline testbench
// Known-answer and edge blocks, then random blocks under several keys with
// random idling on both sides, a long output hold-off, and a checker.
// ----------------------------------------------------------------------------
module tb;
  import aes128_pkg::*;

  localparam int Latency = 11;
  localparam int IdleLimit = 20000;

  logic        clk, rst_n;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [63:0] pwdata, prdata;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [63:0] in_plain_high, in_plain_low, out_cipher_high, out_cipher_low;
  int          mismatches, pending, accepted;
  int          send_idle_pct, recv_idle_pct, hold_off;
  int          idle_cycles;
  int          keys_used;

  aes128_block_encrypt_top dut (.*);

  aes128_cipher_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no progress, %0d results outstanding", pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side stall
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off  <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_key(input logic [3:0] addr, input logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    keys_used++;
  endtask

  task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
    write_key(AddrKeyHigh, hi);
    write_key(AddrKeyLow, lo);
  endtask

  // Offer one request and hold it until taken
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; in_plain_high <= hi; in_plain_low <= lo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [63:0] k_hi, k_lo;
    rst_n = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0; in_valid = 1'b0; in_plain_high = '0; in_plain_low = '0;
    out_stall = 1'b0; hold_off = 0; idle_cycles = 0; keys_used = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset key, standard vector, extremes
    send_block('0, '0);
    send_block('1, '1);
    drain();
    set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(64'h8000000000000000, 64'h0000000000000001);
    drain();
    set_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
    drain();
    set_key('1, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    drain();
    // Key change with the pipeline drained, then one block under the new key
    set_key('0, '0);
    send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain();

    // Random: three idling phases, new key per phase block
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 48 : 0;
      recv_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 8 : 0;
      for (int s = 0; s < 4; s++) begin
        k_hi = rand64();
        k_lo = rand64();
        set_key(k_hi, k_lo);
        if (ph == 2 && s == 0) hold_off = 200;
        for (int i = 0; i < 90; i++) send_block(rand64(), rand64());
        drain();
      end
    end

    $display("covered %0d blocks under %0d key writes, fixed and random keys,",
             accepted, keys_used);
    $display("with both sides idling and a long result hold-off");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/aes128_pkg.sv
rtl/core/aes128_round_cell.sv
rtl/core/aes128_block_encrypt_top.sv
tb/aes128_cipher_checker.sv
tb/tb.sv
